[rtl/ctse_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ctse_pkg
// Shared types, constants and helpers for the client table with stale
// entry eviction.
// ----------------------------------------------------------------------------
package ctse_pkg;

    // Pool geometry
    localparam int ENTRIES = 64;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    // Field widths
    localparam int KEY_W   = 64;
    localparam int STAMP_W = 48;
    localparam int TMO_W   = 32;
    localparam int OIDX_W  = 6;

    localparam logic [TMO_W-1:0] STALE_RESET = TMO_W'(30000);

    typedef enum logic [2:0] {
        ST_FOUND   = 3'd0,
        ST_FILL    = 3'd1,
        ST_STALE   = 3'd2,
        ST_BLOCKED = 3'd3,
        ST_FULL    = 3'd4,
        ST_CLEARED = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_STALE
    } state_t;

    typedef enum logic {
        CMP_KEY,
        CMP_STALE
    } cmp_mode_t;

    typedef struct packed {
        logic               cmd;
        logic [KEY_W-1:0]   peer_addr;
        logic [STAMP_W-1:0] now_ms;
        logic               host_blocked;
    } ctse_req_t;

    typedef struct packed {
        status_t            status;
        logic [OIDX_W-1:0]  entry_index;
        logic [KEY_W-1:0]   evicted_addr;
        logic               record_host;
    } ctse_rsp_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

    // Map a pool index onto the 6-bit result field (mask or zero extend)
    function automatic logic [OIDX_W-1:0] idx_out(input logic [IDX_W-1:0] i);
        logic [IDX_W+OIDX_W-1:0] t;
        t = {{OIDX_W{1'b0}}, i};
        return t[OIDX_W-1:0];
    endfunction

    function automatic ctse_rsp_t make_rsp(input status_t st,
                                           input logic [OIDX_W-1:0] idx,
                                           input logic [KEY_W-1:0] evicted,
                                           input logic rec);
        ctse_rsp_t r;
        r.status       = st;
        r.entry_index  = idx;
        r.evicted_addr = evicted;
        r.record_host  = rec;
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/ctse_store.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ctse_store
// Entry memory: key and time stamp per pool slot, one write port and one
// read port with registered read data.
// ----------------------------------------------------------------------------
module ctse_store
    import ctse_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [IDX_W-1:0] wr_addr,
    input  wire entry_t           wr_data,
    input  wire logic             rd_en,
    input  wire logic [IDX_W-1:0] rd_addr,
    output entry_t                rd_data
);

    entry_t mem [ENTRIES];
    entry_t rd_data_reg;

    // Write one slot
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Register read data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

[rtl/ctse_cmp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ctse_cmp
// Shared compare unit: key equality during lookup, age test during the
// stale scan.
// ----------------------------------------------------------------------------
module ctse_cmp
    import ctse_pkg::*;
(
    input  wire cmp_mode_t          mode,
    input  wire entry_t             entry,
    input  wire logic [KEY_W-1:0]   key,
    input  wire logic [STAMP_W-1:0] now_ms,
    input  wire logic [TMO_W-1:0]   timeout,
    output logic                    hit
);

    logic [STAMP_W:0] age;

    // Age with borrow; a borrow means the clock went backwards
    assign age = {1'b0, now_ms} - {1'b0, entry.stamp};

    always_comb
    begin
        unique case (mode)
            CMP_KEY:   hit = (entry.key == key);
            CMP_STALE: hit = !age[STAMP_W] &&
                             (age[STAMP_W-1:0] > {{(STAMP_W-TMO_W){1'b0}}, timeout});
            default:   hit = 1'b0;
        endcase
    end

endmodule
`default_nettype wire

[rtl/client_table_stale_evict_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// client_table_stale_evict_top
// Client pool keyed by peer address with fill and stale-entry replacement.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A clear answers on
// the next cycle without raising busy. An insert first walks the filled
// entries, one per cycle through the single read port of the entry memory;
// if the pool is full, the address missed and the host is not blocked, a
// second walk over all ENTRIES slots looks for a stale entry. The result
// then shows on rsp with done high for one cycle. The receiver cannot
// stall: capture rsp whenever done is high. Write the stale timeout through
// cfg_we/cfg_wdata only while the block is idle.
// ----------------------------------------------------------------------------
module client_table_stale_evict_top
    import ctse_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire ctse_req_t        req,
    input  wire logic             cfg_we,
    input  wire logic [TMO_W-1:0] cfg_wdata,
    output logic                  done,
    output ctse_rsp_t             rsp
);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   issue_reg, issue_next;
    logic [IDX_W-1:0]   chk_ptr_reg, chk_ptr_next;
    logic               chk_valid_reg, chk_valid_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic               done_reg, done_next;
    ctse_req_t          req_reg, req_next;
    ctse_rsp_t          rsp_reg, rsp_next;
    logic [TMO_W-1:0]   timeout_reg;

    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    entry_t             rd_data;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    entry_t             wr_data;
    cmp_mode_t          cmp_mode;
    logic               hit;
    logic [CNT_W-1:0]   scan_limit;

    ctse_store u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ctse_cmp u_cmp (
        .mode    (cmp_mode),
        .entry   (rd_data),
        .key     (req_reg.peer_addr),
        .now_ms  (req_reg.now_ms),
        .timeout (timeout_reg),
        .hit     (hit)
    );

    // Hold the stale timeout
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= STALE_RESET;
        end
        else if (cfg_we)
        begin
            timeout_reg <= cfg_wdata;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            issue_reg     <= '0;
            chk_valid_reg <= 1'b0;
            fill_reg      <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_reg     <= issue_next;
            chk_valid_reg <= chk_valid_next;
            fill_reg      <= fill_next;
            done_reg      <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        chk_ptr_reg <= chk_ptr_next;
        req_reg     <= req_next;
        rsp_reg     <= rsp_next;
    end

    assign cmp_mode   = (state_reg == S_STALE) ? CMP_STALE : CMP_KEY;
    assign scan_limit = (state_reg == S_STALE) ? CNT_W'(ENTRIES) : fill_reg;
    assign rd_addr    = issue_reg[IDX_W-1:0];
    assign wr_data    = '{key: req_reg.peer_addr, stamp: req_reg.now_ms};

    // Sequence the lookup and stale passes
    always_comb
    begin
        state_next     = state_reg;
        issue_next     = issue_reg;
        chk_ptr_next   = chk_ptr_reg;
        chk_valid_next = 1'b0;
        fill_next      = fill_reg;
        done_next      = 1'b0;
        req_next       = req_reg;
        rsp_next       = rsp_reg;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = fill_reg[IDX_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (req.cmd)
                    begin
                        // Clear: drop all entries and answer at once
                        fill_next = '0;
                        rsp_next  = make_rsp(ST_CLEARED, '0, '0, 1'b0);
                        done_next = 1'b1;
                    end
                    else
                    begin
                        req_next   = req;
                        issue_next = '0;
                        state_next = S_LOOKUP;
                    end
                end
            end

            S_LOOKUP, S_STALE:
            begin
                if (chk_valid_reg && hit)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                    if (state_reg == S_LOOKUP)
                    begin
                        rsp_next = make_rsp(ST_FOUND, idx_out(chk_ptr_reg), '0, 1'b0);
                    end
                    else
                    begin
                        // Replace the stale slot and report its old key
                        wr_en    = 1'b1;
                        wr_addr  = chk_ptr_reg;
                        rsp_next = make_rsp(ST_STALE, idx_out(chk_ptr_reg),
                                            rd_data.key, 1'b1);
                    end
                end
                else if (issue_reg < scan_limit)
                begin
                    // Advance: read the next slot, check it next cycle
                    rd_en          = 1'b1;
                    chk_valid_next = 1'b1;
                    chk_ptr_next   = issue_reg[IDX_W-1:0];
                    issue_next     = issue_reg + CNT_W'(1);
                end
                else if (state_reg == S_STALE)
                begin
                    rsp_next   = make_rsp(ST_FULL, '0, '0, 1'b0);
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    // Lookup missed
                    priority if (req_reg.host_blocked)
                    begin
                        rsp_next   = make_rsp(ST_BLOCKED, '0, '0, 1'b0);
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else if (fill_reg < CNT_W'(ENTRIES))
                    begin
                        wr_en      = 1'b1;
                        fill_next  = fill_reg + CNT_W'(1);
                        rsp_next   = make_rsp(ST_FILL, idx_out(fill_reg[IDX_W-1:0]),
                                              '0, 1'b1);
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        issue_next = '0;
                        state_next = S_STALE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    // Checks
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(ENTRIES))
        else $error("fill count beyond pool size");

    a_record: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rsp.record_host ==
                  ((rsp.status == ST_FILL) || (rsp.status == ST_STALE))))
        else $error("record_host disagrees with status");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req.cmd) |=>
            (done && (rsp.status == ST_CLEARED) && (fill_reg == '0)))
        else $error("clear request not answered");

endmodule
`default_nettype wire

[tb/client_table_stale_evict_top_tb.sv]
// ----------------------------------------------------------------------------
// client_table_stale_evict_top_tb
// Self-checking bench for the client table with stale entry eviction. A
// short table of typed requests covers the field extremes, hits on barred
// hosts, blocked misses and clears; random episodes then clear the pool,
// fill it, and run lookups, misses, stale replacements and full rejections
// under several timeout settings. Directed results are checked against
// hand-read values, random ones against an in-bench model of the pool.
// ----------------------------------------------------------------------------
module client_table_stale_evict_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ctse_pkg::*;

    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 150;
    localparam int MAX_REPORTS  = 10;
    localparam int ITEM_TARGET  = 400;

    typedef struct {
        ctse_req_t rq;
        ctse_rsp_t rsp;
    } plan_row_t;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    ctse_req_t        req;
    logic             cfg_we;
    logic [TMO_W-1:0] cfg_wdata;
    logic             done;
    ctse_rsp_t        rsp;

    // Bench copy of the pool
    logic [KEY_W-1:0]   pool_key   [ENTRIES];
    logic [STAMP_W-1:0] pool_stamp [ENTRIES];
    int                 pool_fill;
    logic [TMO_W-1:0]   tmo_ms;

    ctse_rsp_t          awaited_rsp [$];
    plan_row_t          plan [$];
    int                 fail_count  = 0;
    int                 idle_cycles = 0;
    int                 items_sent  = 0;
    bit                 no_gaps     = 1'b0;
    logic [STAMP_W-1:0] clock_ms;

    client_table_stale_evict_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .done      (done),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [KEY_W-1:0] rand_addr();
        return {$urandom, $urandom};
    endfunction

    function automatic void note_error(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("ERROR at %0t: %s", $time, msg);
    endfunction

    // Work out the result of one request and update the pool copy
    function automatic ctse_rsp_t table_outcome(input ctse_req_t r);
        ctse_rsp_t o;
        int        i;
        o = '0;
        if (r.cmd)
        begin
            pool_fill = 0;
            o.status  = ST_CLEARED;
            return o;
        end
        for (i = 0; i < pool_fill; i++)
        begin
            if (pool_key[i] == r.peer_addr)
            begin
                o.status      = ST_FOUND;
                o.entry_index = OIDX_W'(i);
                return o;
            end
        end
        if (r.host_blocked)
        begin
            o.status = ST_BLOCKED;
            return o;
        end
        if (pool_fill < ENTRIES)
        begin
            pool_key[pool_fill]   = r.peer_addr;
            pool_stamp[pool_fill] = r.now_ms;
            o.status      = ST_FILL;
            o.entry_index = OIDX_W'(pool_fill);
            o.record_host = 1'b1;
            pool_fill++;
            return o;
        end
        // Pool full: take the first entry in pool order that has gone stale
        for (i = 0; i < ENTRIES; i++)
        begin
            if (r.now_ms >= pool_stamp[i] && (r.now_ms - pool_stamp[i]) > tmo_ms)
            begin
                o.status       = ST_STALE;
                o.entry_index  = OIDX_W'(i);
                o.evicted_addr = pool_key[i];
                o.record_host  = 1'b1;
                pool_key[i]    = r.peer_addr;
                pool_stamp[i]  = r.now_ms;
                return o;
            end
        end
        o.status = ST_FULL;
        return o;
    endfunction

    // Move the time stamp on: small steps, jumps around the timeout, large
    // random jumps, and now and then a step backwards
    function automatic void advance_clock();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            clock_ms += STAMP_W'($urandom_range(0, 20));
        else if (pick < 85)
            clock_ms = clock_ms + STAMP_W'(tmo_ms) + STAMP_W'($urandom_range(0, 2)) - 48'd1;
        else if (pick < 93)
            clock_ms -= STAMP_W'($urandom_range(1, 500));
        else
            clock_ms += STAMP_W'($urandom);
    endfunction

    task automatic add_row(input logic c, input logic [KEY_W-1:0] a,
                           input logic [STAMP_W-1:0] t, input logic b,
                           input status_t st, input int idx, input logic rec);
        plan_row_t row;
        row.rq.cmd           = c;
        row.rq.peer_addr     = a;
        row.rq.now_ms        = t;
        row.rq.host_blocked  = b;
        row.rsp.status       = st;
        row.rsp.entry_index  = OIDX_W'(idx);
        row.rsp.evicted_addr = '0;
        row.rsp.record_host  = rec;
        plan.push_back(row);
    endtask

    // Present one request after a random gap and hold it until taken
    task automatic send_req(input ctse_req_t r, input bit typed, input ctse_rsp_t want);
        int        gap;
        ctse_rsp_t got;
        gap = 0;
        if (!no_gaps)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: gap = 0;
                9:          gap = $urandom_range(8, 40);
                default:    gap = $urandom_range(1, 3);
            endcase
        end
        if (gap > 0)
        begin
            start            = 1'b0;
            req.cmd          = 1'($urandom);
            req.peer_addr    = rand_addr();
            req.now_ms       = STAMP_W'(rand_addr());
            req.host_blocked = 1'($urandom);
            repeat (gap) @(negedge clk);
        end
        req   = r;
        start = 1'b1;
        do
            @(posedge clk);
        while (busy);
        got = table_outcome(r);
        awaited_rsp.push_back(typed ? want : got);
        items_sent++;
        @(negedge clk);
    endtask

    // Write the stale timeout once the block has gone quiet
    task automatic set_timeout(input logic [TMO_W-1:0] v);
        start = 1'b0;
        while (awaited_rsp.size() != 0 || busy)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_wdata = v;
        cfg_we    = 1'b1;
        @(negedge clk);
        cfg_we = 1'b0;
        tmo_ms = v;
    endtask

    // Clear, fill the pool up to a target, then mix lookups, misses and clears
    task automatic run_episode(input int ep);
        ctse_req_t r;
        ctse_rsp_t blank_rsp;
        int        target;
        int        i;
        int        pick;
        blank_rsp = '0;
        no_gaps   = ($urandom_range(0, 3) == 0);
        r             = '0;
        r.cmd         = 1'b1;
        r.peer_addr   = rand_addr();
        r.now_ms      = clock_ms;
        send_req(r, 1'b0, blank_rsp);
        clock_ms = STAMP_W'(rand_addr());
        target   = (ep % 3 == 2) ? $urandom_range(1, 40) : ENTRIES;
        while (pool_fill < target)
        begin
            advance_clock();
            r.cmd          = 1'b0;
            r.now_ms       = clock_ms;
            r.host_blocked = ($urandom_range(0, 9) == 0);
            if (pool_fill > 0 && $urandom_range(0, 7) == 0)
                r.peer_addr = pool_key[$urandom_range(0, pool_fill - 1)];
            else
                r.peer_addr = rand_addr();
            send_req(r, 1'b0, blank_rsp);
        end
        for (i = 0; i < 40; i++)
        begin
            advance_clock();
            pick           = $urandom_range(0, 99);
            r.cmd          = (pick < 3);
            r.now_ms       = clock_ms;
            r.host_blocked = 1'b0;
            r.peer_addr    = rand_addr();
            if (pick >= 3 && pick < 38 && pool_fill > 0)
            begin
                r.peer_addr    = pool_key[$urandom_range(0, pool_fill - 1)];
                r.host_blocked = 1'($urandom);
            end
            else if (pick >= 38 && pick < 53)
                r.host_blocked = 1'b1;
            send_req(r, 1'b0, blank_rsp);
        end
    endtask

    // Check each result against the oldest expected one
    always @(posedge clk)
    begin : check_rsp
        ctse_rsp_t want;
        if (rst_n && done)
        begin
            if (awaited_rsp.size() == 0)
                note_error($sformatf("unexpected result status %0d index %0d",
                                     rsp.status, rsp.entry_index));
            else
            begin
                want = awaited_rsp.pop_front();
                if (rsp.status !== want.status || rsp.entry_index !== want.entry_index ||
                    rsp.evicted_addr !== want.evicted_addr ||
                    rsp.record_host !== want.record_host)
                    note_error($sformatf(
                        "exp st %0d idx %0d ev %h rec %0d, got st %0d idx %0d ev %h rec %0d",
                        want.status, want.entry_index, want.evicted_addr, want.record_host,
                        rsp.status, rsp.entry_index, rsp.evicted_addr, rsp.record_host));
            end
        end
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int i;
        int ep;
        start     = 1'b0;
        req       = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        rst_n     = 1'b0;
        pool_fill = 0;
        tmo_ms    = STALE_RESET;
        clock_ms  = '0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed requests with hand-read results
        add_row(1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1, ST_CLEARED, 0, 1'b0);
        add_row(1'b0, 64'h0, 48'h0, 1'b0, ST_FILL, 0, 1'b1);
        add_row(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b0, ST_FILL, 1, 1'b1);
        add_row(1'b0, 64'h0, 48'hFFFF_FFFF_FFFF, 1'b1, ST_FOUND, 0, 1'b0);
        add_row(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 48'h0, 1'b1, ST_FOUND, 1, 1'b0);
        add_row(1'b0, 64'h5555_5555_5555_5555, 48'h1, 1'b1, ST_BLOCKED, 0, 1'b0);
        add_row(1'b0, 64'hAAAA_AAAA_AAAA_AAAA, 48'h5555_5555_5555, 1'b0, ST_FILL, 2, 1'b1);
        add_row(1'b0, 64'h5555_5555_5555_5555, 48'hAAAA_AAAA_AAAA, 1'b0, ST_FILL, 3, 1'b1);
        add_row(1'b0, 64'hAAAA_AAAA_AAAA_AAAA, 48'hAAAA_AAAA_AAAA, 1'b1, ST_FOUND, 2, 1'b0);
        add_row(1'b1, 64'h0, 48'h0, 1'b0, ST_CLEARED, 0, 1'b0);
        add_row(1'b0, 64'hAAAA_AAAA_AAAA_AAAA, 48'h10, 1'b0, ST_FILL, 0, 1'b1);
        add_row(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 48'h20, 1'b0, ST_FILL, 1, 1'b1);
        add_row(1'b0, 64'h0, 48'h30, 1'b1, ST_BLOCKED, 0, 1'b0);
        add_row(1'b0, 64'h1, 48'h40, 1'b0, ST_FILL, 2, 1'b1);
        add_row(1'b0, 64'h8000_0000_0000_0000, 48'h50, 1'b0, ST_FILL, 3, 1'b1);
        add_row(1'b0, 64'h1, 48'h60, 1'b0, ST_FOUND, 2, 1'b0);
        add_row(1'b0, 64'h8000_0000_0000_0000, 48'h70, 1'b1, ST_FOUND, 3, 1'b0);
        add_row(1'b1, 64'h1234_5678_9ABC_DEF0, 48'h8000_0000_0000, 1'b1, ST_CLEARED, 0, 1'b0);
        add_row(1'b1, 64'h0, 48'h0, 1'b0, ST_CLEARED, 0, 1'b0);
        add_row(1'b0, 64'h0123_4567_89AB_CDEF, 48'h7FFF_FFFF_FFFF, 1'b0, ST_FILL, 0, 1'b1);
        for (i = 0; i < plan.size(); i++)
            send_req(plan[i].rq, 1'b1, plan[i].rsp);

        // Random episodes, each under its own timeout
        ep = 0;
        while (items_sent < ITEM_TARGET)
        begin
            case (ep)
                0:       ;
                1:       set_timeout('0);
                2:       set_timeout('1);
                3:       set_timeout(TMO_W'(1));
                default: set_timeout($urandom_range(0, 1) ? $urandom
                                                          : $urandom_range(1, 3000));
            endcase
            run_episode(ep);
            ep++;
        end

        // Drain and report
        start = 1'b0;
        while (awaited_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[filelist.f]
rtl/ctse_pkg.sv
rtl/ctse_store.sv
rtl/ctse_cmp.sv
rtl/client_table_stale_evict_top.sv
tb/client_table_stale_evict_top_tb.sv
